@@ src/wfr_pkg.sv @@
package wfr_pkg;

	// Largest ping payload that is echoed as a pong
	localparam logic [6:0] PING_MAX = 7'd64;

	// Opcodes in the low nibble of the header byte
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// Header bytes sent toward the peer
	localparam logic [7:0] TX_CLOSE_HDR = 8'h88;
	localparam logic [7:0] TX_PONG_HDR  = 8'h8A;

	localparam logic [6:0] MAX_LEN_RESET = 7'd127;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_LENGTH  = 5'b00010,
		PH_MASK    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CLOSED  = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BINARY = 2'd0,
		KIND_PING   = 2'd1,
		KIND_CLOSE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		EV_PAYLOAD    = 4'd0,
		EV_TX         = 4'd1,
		EV_EMPTY      = 4'd2,
		EV_NOT_FINAL  = 4'd3,
		EV_UNMASKED   = 4'd4,
		EV_TOO_LONG   = 4'd5,
		EV_PONG       = 4'd6,
		EV_TEXT       = 4'd7,
		EV_UNKNOWN    = 4'd8,
		EV_CLOSED     = 4'd9
	} event_t;

	typedef struct packed {
		phase_t          phase;
		kind_t           kind;
		logic [3:0][7:0] mask_key;
		logic [1:0]      mask_count;
		logic [6:0]      frame_length;
		logic [6:0]      byte_position;
		logic            length_rejected;
	} rx_state_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [6:0] idx;
		logic       fend;
		logic       open;
	} result_t;

	typedef struct packed {
		result_t res;
		logic    last;
	} out_item_t;

endpackage

@@ src/websocket_frame_receiver.sv @@
// Receive side of a server WebSocket link, one byte per request on the input
// channel. Each accepted byte updates the frame parser and yields zero, one or
// two results (payload bytes unmasked, bytes to transmit, status events), which
// appear on the output channel in the cycle after the byte is taken. A byte that
// yields at most one result is taken every cycle while the output side keeps up;
// a byte that yields two (pong header, close reply) holds the input until the first
// is read; the two-entry buffer drains one result per cycle while out_ready is high.
// Binary frame lengths above max_binary_length (reset 127) are rejected; write it
// only while the block is idle. After a close the link stays closed until reset.
module websocket_frame_receiver import wfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] max_binary_length,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_res,
	output logic [7:0] data,
	output logic [6:0] payload_index,
	output logic       frame_end,
	output logic       link_open,
	output logic       last
);

	rx_state_t    st_q;
	rx_state_t    st_next;
	logic [6:0]   max_len_q;
	result_t      res0;
	result_t      res1;
	logic [1:0]   nres;
	out_item_t    slot_q [2];
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	wfr_step u_step (
		.st      (st_q),
		.rx_byte (rx_byte),
		.max_len (max_len_q),
		.st_next (st_next),
		.res0    (res0),
		.res1    (res1),
		.nres    (nres)
	);

	assign cfg_ready = 1'b1;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	// take a new request once the buffer will be empty by the next edge
	assign in_ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign push      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PH_HEADER;
			st_q.kind            <= KIND_BINARY;
			st_q.mask_key        <= '0;
			st_q.mask_count      <= 2'd0;
			st_q.frame_length    <= 7'd0;
			st_q.byte_position   <= 7'd0;
			st_q.length_rejected <= 1'b0;
			max_len_q            <= MAX_LEN_RESET;
			cnt_q                <= 2'd0;
		end else begin
			if (cfg_valid)
				max_len_q <= max_binary_length;
			if (push) begin
				st_q  <= st_next;
				cnt_q <= nres;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[0].res  <= res0;
			slot_q[0].last <= nres == 2'd1;
			slot_q[1].res  <= res1;
			slot_q[1].last <= 1'b1;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

	assign event_res     = slot_q[0].res.ev;
	assign data          = slot_q[0].res.data;
	assign payload_index = slot_q[0].res.idx;
	assign frame_end     = slot_q[0].res.fend;
	assign link_open     = slot_q[0].res.open;
	assign last          = slot_q[0].last;

endmodule

@@ src/wfr_step.sv @@
module wfr_step import wfr_pkg::*; (
	input  rx_state_t  st,
	input  logic [7:0] rx_byte,
	input  logic [6:0] max_len,
	output rx_state_t  st_next,
	output result_t    res0,
	output result_t    res1,
	output logic [1:0] nres
);

	logic [3:0] opcode;
	logic [6:0] len_in;
	logic       rejected;
	logic [7:0] mask_byte;
	logic [7:0] unmasked;
	logic       at_end;

	function automatic result_t mk(event_t ev, logic [7:0] d, logic [6:0] idx,
			logic fend, logic open);
		result_t r;
		r.ev   = ev;
		r.data = d;
		r.idx  = idx;
		r.fend = fend;
		r.open = open;
		return r;
	endfunction

	assign opcode    = rx_byte[3:0];
	assign len_in    = rx_byte[6:0];
	assign mask_byte = st.mask_key[st.byte_position[1:0]];
	assign unmasked  = rx_byte ^ mask_byte;
	assign at_end    = ({1'b0, st.byte_position} + 8'd1) >= {1'b0, st.frame_length};

	always_comb begin
		st_next = st;
		res0    = mk(EV_PAYLOAD, 8'd0, 7'd0, 1'b0, 1'b1);
		res1    = mk(EV_TX, 8'd0, 7'd0, 1'b0, 1'b0);
		nres    = 2'd0;
		rejected = 1'b0;

		case (st.phase)
			PH_HEADER: begin
				nres = 2'd1;
				if (!rx_byte[7]) begin
					res0.ev = EV_NOT_FINAL;
				end else if (opcode == OP_CLOSE) begin
					st_next.kind  = KIND_CLOSE;
					st_next.phase = PH_LENGTH;
					nres = 2'd0;
				end else if (opcode == OP_PING) begin
					st_next.kind  = KIND_PING;
					st_next.phase = PH_LENGTH;
					nres = 2'd0;
				end else if (opcode == OP_BINARY) begin
					st_next.kind  = KIND_BINARY;
					st_next.phase = PH_LENGTH;
					nres = 2'd0;
				end else if (opcode == OP_PONG) begin
					res0.ev = EV_PONG;
				end else if (opcode == OP_TEXT) begin
					res0.ev = EV_TEXT;
				end else begin
					res0.ev = EV_UNKNOWN;
				end
			end
			PH_LENGTH: begin
				if (!rx_byte[7]) begin
					if (st.kind == KIND_CLOSE) begin
						// answer the close at once and shut the link
						res0 = mk(EV_TX, TX_CLOSE_HDR, 7'd0, 1'b0, 1'b0);
						res1 = mk(EV_TX, 8'h00, 7'd0, 1'b0, 1'b0);
						nres = 2'd2;
						st_next.phase = PH_CLOSED;
					end else begin
						res0.ev = EV_UNMASKED;
						nres = 2'd1;
						st_next.phase = PH_HEADER;
					end
				end else begin
					if (st.kind == KIND_BINARY) begin
						rejected = len_in > max_len;
					end else if (st.kind == KIND_PING) begin
						rejected = len_in > PING_MAX;
						if (!rejected) begin
							res0 = mk(EV_TX, TX_PONG_HDR, 7'd0, 1'b0, 1'b1);
							res1 = mk(EV_TX, {1'b0, len_in}, 7'd0, 1'b0, 1'b1);
							nres = 2'd2;
						end
					end
					st_next.frame_length    = len_in;
					st_next.mask_key        = '0;
					st_next.mask_count      = 2'd0;
					st_next.byte_position   = 7'd0;
					st_next.length_rejected = rejected;
					st_next.phase           = PH_MASK;
				end
			end
			PH_MASK: begin
				st_next.mask_key[st.mask_count] = st.mask_key[st.mask_count] | rx_byte;
				st_next.mask_count = st.mask_count + 2'd1;
				if (st.mask_count == 2'd3) begin
					if (st.kind == KIND_CLOSE) begin
						res0 = mk(EV_TX, TX_CLOSE_HDR, 7'd0, 1'b0, 1'b0);
						res1 = mk(EV_TX, 8'h00, 7'd0, 1'b0, 1'b0);
						nres = 2'd2;
						st_next.phase = PH_CLOSED;
					end else if (st.length_rejected) begin
						res0.ev = EV_TOO_LONG;
						nres = 2'd1;
						st_next.phase = PH_HEADER;
					end else if (st.frame_length == 7'd0) begin
						// an empty ping already sent its whole pong
						if (st.kind == KIND_BINARY) begin
							res0.ev = EV_EMPTY;
							nres = 2'd1;
						end
						st_next.phase = PH_HEADER;
					end else begin
						st_next.phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				nres = 2'd1;
				if (st.kind == KIND_PING)
					res0 = mk(EV_TX, unmasked, st.byte_position, 1'b0, 1'b1);
				else
					res0 = mk(EV_PAYLOAD, unmasked, st.byte_position, at_end, 1'b1);
				st_next.byte_position = st.byte_position + 7'd1;
				if (at_end)
					st_next.phase = PH_HEADER;
			end
			default: begin
				st_next.phase = PH_CLOSED;
				res0 = mk(EV_CLOSED, 8'd0, 7'd0, 1'b0, 1'b0);
				nres = 2'd1;
			end
		endcase
	end

endmodule
